// ===== sv/qxmm_pkg.sv =====
// Shared types and constants for the quad X motor mixer.
package qxmm_pkg;

  // Widths of the fixed fields
  localparam int MIX_W   = 18;  // signed sum of four 16-bit terms
  localparam int LVL_W   = 15;  // level field width
  localparam int PULSE_W = 12;  // pulse field width
  localparam int DIFF_W  = 13;  // signed max - min
  localparam int CFG_W   = 15;  // widest register
  localparam int IDX_W   = 2;

  // Divide by 100 through a reciprocal: exact for any value below 2^QOFF_W
  localparam int QOFF_W    = 20;
  localparam int RECIP_M_W = 21;
  localparam int RECIP_SH  = 27;
  localparam int REC_W     = QOFF_W + RECIP_M_W;
  localparam int QD_W      = REC_W - RECIP_SH;
  localparam logic [RECIP_M_W-1:0] RECIP_M = 21'd1342178;

  // Quotient bias: 100 * 4096 added before dividing, 4096 taken off after
  localparam logic [QOFF_W:0]          DIV_BIAS  = 21'd409600;
  localparam logic signed [QD_W-1:0]   QUOT_BIAS = 14'sd4096;
  localparam int                       SQ_W      = QOFF_W + 1;

  // Register reset values
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd1000;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2000;
  localparam logic [LVL_W-1:0]   MIN_MOTOR_RST = 15'd2560;

  typedef enum logic [IDX_W-1:0] {
    CFG_MIN_PULSE = 2'd0,
    CFG_MAX_PULSE = 2'd1,
    CFG_MIN_MOTOR = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse;
    logic [PULSE_W-1:0] max_pulse;
  } pulse_cfg_t;

endpackage

// ===== sv/qxmm_pulse.sv =====
// Level to pulse width mapping for one motor: three register stages.
module qxmm_pulse #(
  parameter int FRAC_BITS = 8,
  localparam int FS = 100 * (2 ** FRAC_BITS),
  localparam int LW = $clog2(FS + 1)
) (
  input  logic                        clk,
  input  qxmm_pkg::pulse_cfg_t        cfg,
  input  logic [LW-1:0]               level,
  output logic [qxmm_pkg::PULSE_W-1:0] pulse
);

  localparam int PW = LW + 1 + qxmm_pkg::DIFF_W;

  logic signed [qxmm_pkg::DIFF_W-1:0] diff;
  logic signed [PW-1:0]               prod_nxt, prod_r, shifted;
  logic signed [qxmm_pkg::SQ_W-1:0]   quot_s;
  logic [qxmm_pkg::QOFF_W:0]          biased;
  logic [qxmm_pkg::REC_W-1:0]         rec_nxt, rec_r;
  logic signed [qxmm_pkg::QD_W-1:0]   quot;
  logic signed [qxmm_pkg::PULSE_W+2:0] pw, min_s, max_s;
  logic [qxmm_pkg::PULSE_W-1:0]       pulse_nxt, pulse_r;

  assign diff = $signed({1'b0, cfg.max_pulse}) - $signed({1'b0, cfg.min_pulse});
  assign prod_nxt = $signed({1'b0, level}) * diff;

  // floor(x / (100 * 2^F)) = floor(floor(x / 2^F) / 100)
  assign shifted = prod_r >>> FRAC_BITS;
  assign quot_s  = shifted[qxmm_pkg::SQ_W-1:0];
  assign biased  = $unsigned(quot_s) + qxmm_pkg::DIV_BIAS;
  assign rec_nxt = qxmm_pkg::REC_W'(biased[qxmm_pkg::QOFF_W-1:0])
                 * qxmm_pkg::REC_W'(qxmm_pkg::RECIP_M);

  assign quot  = $signed(rec_r[qxmm_pkg::REC_W-1:qxmm_pkg::RECIP_SH]) - qxmm_pkg::QUOT_BIAS;
  assign min_s = $signed({3'b000, cfg.min_pulse});
  assign max_s = $signed({3'b000, cfg.max_pulse});

  always_comb begin
    pw = min_s + (qxmm_pkg::PULSE_W + 3)'(quot);
    if (pw < min_s) begin
      pw = min_s;
    end
    if (pw > max_s) begin
      pw = max_s;
    end
    pulse_nxt = pw[qxmm_pkg::PULSE_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    rec_r   <= rec_nxt;
    pulse_r <= pulse_nxt;
  end

  assign pulse = pulse_r;

endmodule

// ===== sv/quad_x_motor_mixer_core.sv =====
// Quad X motor mixer with air mode: pipelined top level.
//
//  channel | ports                           | transfer
//  --------+---------------------------------+-------------------------------
//  in      | start, busy, in_*               | start && !busy
//  out     | out_valid, out_*                | out_valid (one cycle, no stall)
//  cfg     | cfg_valid, cfg_ready, cfg_*     | cfg_valid && cfg_ready
//
// Six register stages: input, mix + min/max, lift + clamp, product,
// reciprocal divide, pulse clamp. One item per cycle; busy is never
// asserted and cfg_ready is always high.
// Items with throttle <= 0 and no emergency are dropped at the mix stage.
// Reset is synchronous; it clears the valid chain and reloads the registers.
module quad_x_motor_mixer_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            in_base_throttle,
  input  logic signed [15:0]            in_pitch_adj,
  input  logic signed [15:0]            in_roll_adj,
  input  logic signed [15:0]            in_yaw_adj,
  input  logic                          in_emergency,
  output logic                          out_valid,
  output logic [qxmm_pkg::LVL_W-1:0]    out_back_left_level,
  output logic [qxmm_pkg::LVL_W-1:0]    out_front_left_level,
  output logic [qxmm_pkg::LVL_W-1:0]    out_back_right_level,
  output logic [qxmm_pkg::LVL_W-1:0]    out_front_right_level,
  output logic [qxmm_pkg::PULSE_W-1:0]  out_back_left_pulse,
  output logic [qxmm_pkg::PULSE_W-1:0]  out_front_left_pulse,
  output logic [qxmm_pkg::PULSE_W-1:0]  out_back_right_pulse,
  output logic [qxmm_pkg::PULSE_W-1:0]  out_front_right_pulse,
  output logic [3:0]                    out_write_mask,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qxmm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [qxmm_pkg::CFG_W-1:0]    cfg_data
);

  localparam int FS = 100 * (2 ** FRAC_BITS);
  localparam int LW = $clog2(FS + 1);
  localparam int MW = qxmm_pkg::MIX_W;
  localparam int W  = ((LW > MW) ? LW : MW) + 3;
  localparam logic signed [W-1:0] FS_W = W'(FS);

  // ---------------- configuration ----------------
  logic [qxmm_pkg::PULSE_W-1:0] min_pulse_r, max_pulse_r;
  logic [qxmm_pkg::LVL_W-1:0]   min_motor_r;
  qxmm_pkg::pulse_cfg_t         pcfg;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= qxmm_pkg::MIN_PULSE_RST;
      max_pulse_r <= qxmm_pkg::MAX_PULSE_RST;
      min_motor_r <= qxmm_pkg::MIN_MOTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qxmm_pkg::CFG_MIN_PULSE: min_pulse_r <= cfg_data[qxmm_pkg::PULSE_W-1:0];
        qxmm_pkg::CFG_MAX_PULSE: max_pulse_r <= cfg_data[qxmm_pkg::PULSE_W-1:0];
        qxmm_pkg::CFG_MIN_MOTOR: min_motor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pcfg.min_pulse = min_pulse_r;
  assign pcfg.max_pulse = max_pulse_r;

  // ---------------- stage A: input register ----------------
  logic               a_valid_r;
  logic signed [15:0] a_t_r, a_p_r, a_r_r, a_y_r;
  logic               a_emg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_t_r   <= in_base_throttle;
    a_p_r   <= in_pitch_adj;
    a_r_r   <= in_roll_adj;
    a_y_r   <= in_yaw_adj;
    a_emg_r <= in_emergency;
  end

  // ---------------- stage B: mix, lowest and highest ----------------
  logic signed [MW-1:0] t_x, p_x, r_x, y_x;
  logic signed [MW-1:0] m_nxt [4];
  logic signed [MW-1:0] lo01, lo23, hi01, hi23, lo_nxt, hi_nxt;
  logic                 b_valid_nxt;

  logic                 b_valid_r, b_emg_r;
  logic signed [MW-1:0] b_m_r [4];
  logic signed [MW-1:0] b_lo_r, b_hi_r;

  assign t_x = MW'(a_t_r);
  assign p_x = MW'(a_p_r);
  assign r_x = MW'(a_r_r);
  assign y_x = MW'(a_y_r);

  assign m_nxt[0] = t_x + p_x + r_x + y_x;
  assign m_nxt[1] = t_x - p_x + r_x - y_x;
  assign m_nxt[2] = t_x + p_x - r_x - y_x;
  assign m_nxt[3] = t_x - p_x - r_x + y_x;

  assign lo01   = (m_nxt[1] < m_nxt[0]) ? m_nxt[1] : m_nxt[0];
  assign lo23   = (m_nxt[3] < m_nxt[2]) ? m_nxt[3] : m_nxt[2];
  assign hi01   = (m_nxt[1] > m_nxt[0]) ? m_nxt[1] : m_nxt[0];
  assign hi23   = (m_nxt[3] > m_nxt[2]) ? m_nxt[3] : m_nxt[2];
  assign lo_nxt = (lo23 < lo01) ? lo23 : lo01;
  assign hi_nxt = (hi23 > hi01) ? hi23 : hi01;

  // no result for idle throttle outside emergency
  assign b_valid_nxt = a_valid_r && (a_emg_r || (a_t_r > 16'sd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_m_r   <= m_nxt;
    b_lo_r  <= lo_nxt;
    b_hi_r  <= hi_nxt;
    b_emg_r <= a_emg_r;
  end

  // ---------------- stage C: air mode lift and clamp ----------------
  logic signed [W-1:0] lo_w, hi_w, floor_w, lift_a, lift;
  logic                apply_lift;
  logic signed [W-1:0] v [4];
  logic [LW-1:0]       lv_nxt [4];
  logic [3:0]          mask_nxt;

  logic                c_valid_r;
  logic [LW-1:0]       c_lv_r [4];
  logic [3:0]          c_mask_r;

  assign lo_w    = W'(b_lo_r);
  assign hi_w    = W'(b_hi_r);
  assign floor_w = $signed({{(W - qxmm_pkg::LVL_W){1'b0}}, min_motor_r});
  assign lift_a  = floor_w - lo_w;
  assign lift    = ((hi_w + lift_a) > FS_W) ? (FS_W - hi_w) : lift_a;
  // a valid item without emergency has positive throttle here
  assign apply_lift = !b_emg_r && (lo_w < floor_w);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      v[i] = W'(b_m_r[i]) + (apply_lift ? lift : W'(0));
      if (v[i] < W'(0)) begin
        lv_nxt[i] = '0;
      end else if (v[i] > FS_W) begin
        lv_nxt[i] = LW'(FS);
      end else begin
        lv_nxt[i] = v[i][LW-1:0];
      end
      mask_nxt[i] = (lv_nxt[i] != '0) || b_emg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    c_lv_r   <= lv_nxt;
    c_mask_r <= mask_nxt;
  end

  // ---------------- pulse mapping, three stages ----------------
  logic [qxmm_pkg::PULSE_W-1:0] pulse [4];

  for (genvar g = 0; g < 4; g++) begin : g_pulse
    qxmm_pulse #(
      .FRAC_BITS(FRAC_BITS)
    ) u_pulse (
      .clk  (clk),
      .cfg  (pcfg),
      .level(c_lv_r[g]),
      .pulse(pulse[g])
    );
  end

  // levels and mask ride along with the pulse pipeline
  logic [2:0]                 d_valid_r;
  logic [qxmm_pkg::LVL_W-1:0] d1_lvl_r [4], d2_lvl_r [4], d3_lvl_r [4];
  logic [3:0]                 d1_mask_r, d2_mask_r, d3_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= '0;
    end else begin
      d_valid_r <= {d_valid_r[1:0], c_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      d1_lvl_r[i] <= qxmm_pkg::LVL_W'(c_lv_r[i]);
    end
    d2_lvl_r  <= d1_lvl_r;
    d3_lvl_r  <= d2_lvl_r;
    d1_mask_r <= c_mask_r;
    d2_mask_r <= d1_mask_r;
    d3_mask_r <= d2_mask_r;
  end

  assign out_valid             = d_valid_r[2];
  assign out_back_left_level   = d3_lvl_r[0];
  assign out_front_left_level  = d3_lvl_r[1];
  assign out_back_right_level  = d3_lvl_r[2];
  assign out_front_right_level = d3_lvl_r[3];
  assign out_back_left_pulse   = pulse[0];
  assign out_front_left_pulse  = pulse[1];
  assign out_back_right_pulse  = pulse[2];
  assign out_front_right_pulse = pulse[3];
  assign out_write_mask        = d3_mask_r;

  // ---------------- assertions ----------------
  a_emg_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_emergency) |-> ##6 (out_valid && out_write_mask == 4'hF))
    else $error("emergency item did not give a full-mask result");

  a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_emergency && in_base_throttle <= 16'sd0) |-> ##6 !out_valid)
    else $error("idle throttle item produced a result");

  a_mask_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_write_mask[0] || out_back_left_level == '0) &&
                   (out_write_mask[1] || out_front_left_level == '0) &&
                   (out_write_mask[2] || out_back_right_level == '0) &&
                   (out_write_mask[3] || out_front_right_level == '0)))
    else $error("clear mask bit with nonzero level");

endmodule

// ===== sim/motor_mix_checker.sv =====
`timescale 1ns / 100ps
// Monitor for the motor mixer: predicts each motor command from transfers and checks results.
module motor_mix_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [15:0]            in_base_throttle,
  input  logic signed [15:0]            in_pitch_adj,
  input  logic signed [15:0]            in_roll_adj,
  input  logic signed [15:0]            in_yaw_adj,
  input  logic                          in_emergency,
  input  logic                          out_valid,
  input  logic [qxmm_pkg::LVL_W-1:0]    out_back_left_level,
  input  logic [qxmm_pkg::LVL_W-1:0]    out_front_left_level,
  input  logic [qxmm_pkg::LVL_W-1:0]    out_back_right_level,
  input  logic [qxmm_pkg::LVL_W-1:0]    out_front_right_level,
  input  logic [qxmm_pkg::PULSE_W-1:0]  out_back_left_pulse,
  input  logic [qxmm_pkg::PULSE_W-1:0]  out_front_left_pulse,
  input  logic [qxmm_pkg::PULSE_W-1:0]  out_back_right_pulse,
  input  logic [qxmm_pkg::PULSE_W-1:0]  out_front_right_pulse,
  input  logic [3:0]                    out_write_mask,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [qxmm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [qxmm_pkg::CFG_W-1:0]    cfg_data,
  output int                            mismatch_count,
  output int                            pending_cmds,
  output int                            checked_cmds
);

  localparam int FULL_SCALE = 100 << FRAC_BITS;

  // motor order: back left, front left, back right, front right
  typedef struct packed {
    logic [3:0][qxmm_pkg::LVL_W-1:0]   level;
    logic [3:0][qxmm_pkg::PULSE_W-1:0] pulse;
    logic [3:0]                        mask;
  } motor_cmd_t;

  motor_cmd_t                   expected_cmds[$];
  logic [qxmm_pkg::PULSE_W-1:0] min_pulse;
  logic [qxmm_pkg::PULSE_W-1:0] max_pulse;
  logic [qxmm_pkg::LVL_W-1:0]   air_floor;
  string                        motor_name[4] =
    '{"back left", "front left", "back right", "front right"};

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Returns 0 when the command is dropped (no throttle, no emergency).
  function automatic bit predict_motor_cmd(input int t, input int p, input int r, input int y,
                                           input bit emg, output motor_cmd_t cmd);
    int m[4];
    int lo;
    int hi;
    int lift;
    int span;
    int lv;
    int prod;
    int pw;
    int i;
    cmd = '0;
    if (t <= 0 && !emg) return 1'b0;
    m[0] = t + p + r + y;
    m[1] = t - p + r - y;
    m[2] = t + p - r - y;
    m[3] = t - p - r + y;
    // air mode: raise the lowest motor to the floor, capped by the highest at full scale
    if (t > 0 && !emg) begin
      lo = m[0];
      hi = m[0];
      for (i = 1; i < 4; i++) begin
        if (m[i] < lo) lo = m[i];
        if (m[i] > hi) hi = m[i];
      end
      if (lo < int'(air_floor)) begin
        lift = int'(air_floor) - lo;
        if (hi + lift > FULL_SCALE) lift = FULL_SCALE - hi;
        for (i = 0; i < 4; i++) m[i] += lift;
      end
    end
    span = int'(max_pulse) - int'(min_pulse);
    for (i = 0; i < 4; i++) begin
      lv = m[i];
      if (lv < 0) lv = 0;
      if (lv > FULL_SCALE) lv = FULL_SCALE;
      prod = lv * span;
      pw = prod / FULL_SCALE;
      if (prod % FULL_SCALE != 0 && prod < 0) pw--;   // floor, not truncate
      pw += int'(min_pulse);
      if (pw < int'(min_pulse)) pw = int'(min_pulse);
      if (pw > int'(max_pulse)) pw = int'(max_pulse);
      cmd.level[i] = qxmm_pkg::LVL_W'(lv);
      cmd.pulse[i] = qxmm_pkg::PULSE_W'(pw);
      cmd.mask[i]  = (lv > 0) || emg;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    motor_cmd_t got;
    motor_cmd_t want;
    if (!rst_n) begin
      min_pulse = qxmm_pkg::MIN_PULSE_RST;
      max_pulse = qxmm_pkg::MAX_PULSE_RST;
      air_floor = qxmm_pkg::MIN_MOTOR_RST;
      expected_cmds.delete();
      pending_cmds   = 0;
      mismatch_count = 0;
      checked_cmds   = 0;
    end else begin
      if (out_valid) begin
        got.level = {out_front_right_level, out_back_right_level,
                     out_front_left_level, out_back_left_level};
        got.pulse = {out_front_right_pulse, out_back_right_pulse,
                     out_front_left_pulse, out_back_left_pulse};
        got.mask  = out_write_mask;
        if (expected_cmds.size() == 0) begin
          report_mismatch("result count (none outstanding)", 1, 0);
        end else begin
          want = expected_cmds.pop_front();
          checked_cmds++;
          for (int i = 0; i < 4; i++) begin
            if (got.level[i] !== want.level[i])
              report_mismatch({motor_name[i], " level"}, got.level[i], want.level[i]);
            if (got.pulse[i] !== want.pulse[i])
              report_mismatch({motor_name[i], " pulse"}, got.pulse[i], want.pulse[i]);
          end
          if (got.mask !== want.mask)
            report_mismatch("write mask", got.mask, want.mask);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (qxmm_pkg::cfg_idx_t'(cfg_index))
          qxmm_pkg::CFG_MIN_PULSE: min_pulse = cfg_data[qxmm_pkg::PULSE_W-1:0];
          qxmm_pkg::CFG_MAX_PULSE: max_pulse = cfg_data[qxmm_pkg::PULSE_W-1:0];
          qxmm_pkg::CFG_MIN_MOTOR: air_floor = cfg_data[qxmm_pkg::LVL_W-1:0];
          default: ;   // unmapped index, write dropped
        endcase
      end
      if (start && !busy) begin
        if (predict_motor_cmd(in_base_throttle, in_pitch_adj, in_roll_adj, in_yaw_adj,
                              in_emergency, want))
          expected_cmds.push_back(want);
      end
      pending_cmds = expected_cmds.size();
    end
  end

endmodule

// ===== sim/quad_x_motor_mixer_core_test.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the quad X motor mixer: stimulus, register phases and verdict.
module quad_x_motor_mixer_core_test;

  localparam int IDLE_PCT         = 29;
  localparam int RANDOM_PER_PHASE = 190;
  localparam int DRAIN_CYCLES     = 8;     // pipeline depth plus margin
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam logic [qxmm_pkg::IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic signed [15:0]            in_base_throttle;
  logic signed [15:0]            in_pitch_adj;
  logic signed [15:0]            in_roll_adj;
  logic signed [15:0]            in_yaw_adj;
  logic                          in_emergency;
  logic                          out_valid;
  logic [qxmm_pkg::LVL_W-1:0]    out_back_left_level;
  logic [qxmm_pkg::LVL_W-1:0]    out_front_left_level;
  logic [qxmm_pkg::LVL_W-1:0]    out_back_right_level;
  logic [qxmm_pkg::LVL_W-1:0]    out_front_right_level;
  logic [qxmm_pkg::PULSE_W-1:0]  out_back_left_pulse;
  logic [qxmm_pkg::PULSE_W-1:0]  out_front_left_pulse;
  logic [qxmm_pkg::PULSE_W-1:0]  out_back_right_pulse;
  logic [qxmm_pkg::PULSE_W-1:0]  out_front_right_pulse;
  logic [3:0]                    out_write_mask;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [qxmm_pkg::IDX_W-1:0]    cfg_index;
  logic [qxmm_pkg::CFG_W-1:0]    cfg_data;

  int mismatch_count;
  int pending_cmds;
  int checked_cmds;
  int cmds_sent;
  int reg_writes;
  int stall_cycles = 0;
  bit steady;

  quad_x_motor_mixer_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_base_throttle      (in_base_throttle),
    .in_pitch_adj          (in_pitch_adj),
    .in_roll_adj           (in_roll_adj),
    .in_yaw_adj            (in_yaw_adj),
    .in_emergency          (in_emergency),
    .out_valid             (out_valid),
    .out_back_left_level   (out_back_left_level),
    .out_front_left_level  (out_front_left_level),
    .out_back_right_level  (out_back_right_level),
    .out_front_right_level (out_front_right_level),
    .out_back_left_pulse   (out_back_left_pulse),
    .out_front_left_pulse  (out_front_left_pulse),
    .out_back_right_pulse  (out_back_right_pulse),
    .out_front_right_pulse (out_front_right_pulse),
    .out_write_mask        (out_write_mask),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  motor_mix_checker mix_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_base_throttle      (in_base_throttle),
    .in_pitch_adj          (in_pitch_adj),
    .in_roll_adj           (in_roll_adj),
    .in_yaw_adj            (in_yaw_adj),
    .in_emergency          (in_emergency),
    .out_valid             (out_valid),
    .out_back_left_level   (out_back_left_level),
    .out_front_left_level  (out_front_left_level),
    .out_back_right_level  (out_back_right_level),
    .out_front_right_level (out_front_right_level),
    .out_back_left_pulse   (out_back_left_pulse),
    .out_front_left_pulse  (out_front_left_pulse),
    .out_back_right_pulse  (out_back_right_pulse),
    .out_front_right_pulse (out_front_right_pulse),
    .out_write_mask        (out_write_mask),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .mismatch_count        (mismatch_count),
    .pending_cmds          (pending_cmds),
    .checked_cmds          (checked_cmds)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // counts cycles without any transfer on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", stall_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_cmd(input int t, input int p, input int r, input int y, input bit emg);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start            <= 1'b1;
    in_base_throttle <= 16'(t);
    in_pitch_adj     <= 16'(p);
    in_roll_adj      <= 16'(r);
    in_yaw_adj       <= 16'(y);
    in_emergency     <= emg;
    do @(posedge clk); while (busy);
    cmds_sent++;
  endtask

  task automatic send_random_cmd;
    int kind;
    int span;
    int t;
    int p;
    int r;
    int y;
    bit emg;
    kind = $urandom_range(0, 99);
    emg  = ($urandom_range(0, 99) < 12);
    if (kind < 65) begin
      // ordinary flight: positive throttle, moderate or large corrections
      span = ($urandom_range(0, 3) == 0) ? 25600 : 6400;
      t = $urandom_range(1, 25600);
      p = int'($urandom_range(0, 2 * span)) - span;
      r = int'($urandom_range(0, 2 * span)) - span;
      y = int'($urandom_range(0, 2 * span)) - span;
    end else if (kind < 78) begin
      // throttle at or below zero, dropped unless in emergency
      emg = 1'($urandom_range(0, 1));
      t = -int'($urandom_range(0, 25600));
      p = int'($urandom_range(0, 51200)) - 25600;
      r = int'($urandom_range(0, 51200)) - 25600;
      y = int'($urandom_range(0, 51200)) - 25600;
    end else if (kind < 92) begin
      t = int'($urandom_range(0, 51200)) - 25600;
      p = int'($urandom_range(0, 51200)) - 25600;
      r = int'($urandom_range(0, 51200)) - 25600;
      y = int'($urandom_range(0, 51200)) - 25600;
    end else begin
      // anything the 16-bit fields can carry
      t = $urandom();
      p = $urandom();
      r = $urandom();
      y = $urandom();
    end
    send_cmd(t, p, r, y, emg);
  endtask

  task automatic write_reg(input logic [qxmm_pkg::IDX_W-1:0] idx,
                           input logic [qxmm_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // registers change only once the pipeline has drained
  task automatic set_limits(input int lo_us, input int hi_us, input int air_floor);
    @(negedge clk);
    start <= 1'b0;
    wait (pending_cmds == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    // upper bits of the pulse writes are junk and must be dropped
    write_reg(qxmm_pkg::CFG_MIN_PULSE, {3'($urandom()), 12'(lo_us)});
    write_reg(qxmm_pkg::CFG_MAX_PULSE, {3'($urandom()), 12'(hi_us)});
    write_reg(qxmm_pkg::CFG_MIN_MOTOR, 15'(air_floor));
    if ($urandom_range(0, 1)) write_reg(CFG_UNUSED_IDX, 15'($urandom()));
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random_cmd();
  endtask

  initial begin
    int lo_us;
    int hi_us;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_base_throttle = '0;
    in_pitch_adj     = '0;
    in_roll_adj      = '0;
    in_yaw_adj       = '0;
    in_emergency     = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    cmds_sent        = 0;
    reg_writes       = 0;
    steady           = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed commands under the reset register values
    send_cmd(25600, 0, 0, 0, 1'b0);
    send_cmd(1, 0, 0, 0, 1'b0);                       // lifted to the floor
    send_cmd(0, 0, 0, 0, 1'b0);                       // dropped
    send_cmd(-25600, 0, 0, 0, 1'b0);                  // dropped
    send_cmd(-32768, 0, 0, 0, 1'b0);                  // dropped
    send_cmd(0, 0, 0, 0, 1'b1);                       // emergency, idle throttle
    send_cmd(-25600, 25600, -25600, 25600, 1'b1);     // emergency, no lift
    send_cmd(25600, 0, 0, 0, 1'b1);
    send_cmd(25600, 25600, 25600, 25600, 1'b0);
    send_cmd(12800, -25600, 25600, -25600, 0);
    send_cmd(20000, 20000, 0, 0, 1'b0);               // lift goes negative
    send_cmd(12800, 12800, 0, 0, 1'b0);               // lift cut to zero
    send_cmd(32767, 32767, 32767, 32767, 1'b0);
    send_cmd(-32768, -32768, -32768, -32768, 1'b1);
    send_cmd(100, -25600, 0, 0, 1'b0);
    send_cmd(1, -32768, 32767, -1, 1'b0);
    send_cmd(5000, 1000, -2000, 3000, 1'b0);
    run_random(RANDOM_PER_PHASE);

    set_limits(0, 4095, 0);
    run_random(RANDOM_PER_PHASE);
    set_limits(4095, 0, 32767);                       // max below min, floor above full scale
    run_random(RANDOM_PER_PHASE);
    set_limits(1000, 2000, 25600);
    steady = 1'b1;                                    // back-to-back transfers
    run_random(RANDOM_PER_PHASE);
    steady = 1'b0;
    set_limits(4095, 4095, 2560);
    run_random(RANDOM_PER_PHASE);
    set_limits(0, 0, 0);
    run_random(RANDOM_PER_PHASE);
    repeat (4) begin
      lo_us = $urandom_range(0, 4095);
      hi_us = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                          : $urandom_range(lo_us, 4095);
      set_limits(lo_us, hi_us, $urandom_range(0, 25600));
      run_random(RANDOM_PER_PHASE);
    end

    @(negedge clk);
    start <= 1'b0;
    wait (pending_cmds == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d mixer commands, checked %0d motor results, %0d register writes",
             cmds_sent, checked_cmds, reg_writes);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
